@@ hw/rtl/bir_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bir_pkg
// Shared types and constants for the bilinear image resampler.
// ----------------------------------------------------------------------------
package bir_pkg;

  localparam int SRC_WIDTH      = 256;
  localparam int MAX_SRC_ROWS   = 64;
  localparam int FRAC_BITS      = 16;
  localparam int COL_W          = $clog2(SRC_WIDTH);
  localparam int ROW_W          = $clog2(MAX_SRC_ROWS);
  localparam int ADDR_W         = COL_W + ROW_W;
  localparam int DEPTH          = SRC_WIDTH * MAX_SRC_ROWS;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 9;
  localparam int NUM_W          = 32;
  localparam int DIV_W          = 9;
  localparam int QUO_W          = NUM_W;
  localparam int ACC_W          = 8 + 2 * FRAC_BITS + 2;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT  = 2'd2;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_COMPUTE = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [5:0] src_row;
    logic [7:0] src_col;
    logic [7:0] src_pixel;
    logic [5:0] out_row;
    logic [7:0] out_col;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_pixel;
    logic [5:0] pixel_row;
    logic [7:0] pixel_col;
  } out_item_t;

  // Job handed from front to back: load flag and pixel, numerators, divisors,
  // row and column (load address or output position).
  typedef struct packed {
    logic             load;
    logic [7:0]       pixel;
    logic [NUM_W-1:0] num_x;
    logic [DIV_W-1:0] div_x;
    logic [NUM_W-1:0] num_y;
    logic [DIV_W-1:0] div_y;
    logic [5:0]       row;
    logic [7:0]       col;
  } job_t;

endpackage

@@ hw/rtl/bilinear_image_resampler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_image_resampler
// Bilinear resampling of an 8-bit grayscale image held in on-chip banks.
// ----------------------------------------------------------------------------
// Load items and compute items share one input and are taken at one per
// cycle while in_full is low. Every item passes a four-entry job queue and a
// 32-stage pipelined divider (one quotient bit per stage), so a load reaches
// the four image banks after both; compute items taken after it see the
// pixel and those taken before it do not. A compute item then takes a
// registered read of the four banks and two blend stages before its result
// enters the output queue, from which it reaches the output ports.
// Up to 64 results may be waiting or in flight; past that the back holds
// compute jobs, the job queue fills and in_full rises. While results are
// popped, items are taken back to back.
module bilinear_image_resampler (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  bir_pkg::in_item_t              in_data,
  output logic                           out_empty,
  input  logic                           out_pop,
  output bir_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [bir_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bir_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bir_pkg::*;

  logic [6:0] source_rows_r;
  logic [8:0] out_width_r;
  logic [6:0] out_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_rows_r <= 7'd64;
      out_width_r   <= 9'd256;
      out_height_r  <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOURCE_ROWS: source_rows_r <= cfg_data[6:0];
        REG_OUT_WIDTH:   out_width_r   <= cfg_data;
        REG_OUT_HEIGHT:  out_height_r  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic               job_push, job_full, job_pop, job_empty;
  job_t               job_in, job_out;

  bir_front u_front (
    .in_push, .in_full, .in_data,
    .source_rows(source_rows_r), .out_width(out_width_r), .out_height(out_height_r),
    .job_push, .job(job_in), .job_full
  );

  bir_fifo u_fifo (
    .clk, .rst_n, .push(job_push), .wdata(job_in), .full(job_full),
    .pop(job_pop), .rdata(job_out), .empty(job_empty)
  );

  bir_back u_back (
    .clk, .rst_n, .job_empty, .job(job_out), .job_pop,
    .out_empty, .out_pop, .out_data
  );

endmodule

@@ hw/rtl/bir_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bir_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

@@ hw/rtl/bir_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bir_front
// Accept items and turn each into a job for the back: loads carry their pixel
// and address, compute items their scaled numerators and divisors.
// ----------------------------------------------------------------------------
module bir_front (
  input  logic                      in_push,
  output logic                      in_full,
  input  bir_pkg::in_item_t         in_data,
  input  logic [6:0]                source_rows,
  input  logic [8:0]                out_width,
  input  logic [6:0]                out_height,
  output logic                      job_push,
  output bir_pkg::job_t             job,
  input  logic                      job_full
);
  import bir_pkg::*;

  logic       accept;
  logic [6:0] row_span;

  assign in_full  = job_full;
  assign accept   = in_push && !in_full;
  assign row_span = (source_rows > 7'd0) ? source_rows - 7'd1 : 7'd0;

  assign job_push         = accept;
  assign job.load         = (in_data.mode == MODE_LOAD);
  assign job.pixel        = in_data.src_pixel;
  assign job.num_x        = NUM_W'({16'(in_data.out_col) * 16'(SRC_WIDTH - 1), 16'd0});
  assign job.div_x        = out_width;
  assign job.num_y        = NUM_W'({16'(in_data.out_row) * 16'(row_span), 16'd0});
  assign job.div_y        = DIV_W'(out_height);
  assign job.row          = job.load ? in_data.src_row : in_data.out_row;
  assign job.col          = job.load ? in_data.src_col : in_data.out_col;

endmodule

@@ hw/rtl/bir_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bir_fifo
// Short register queue between front and back.
// ----------------------------------------------------------------------------
module bir_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bir_pkg::job_t wdata,
  output logic          full,
  input  logic          pop,
  output bir_pkg::job_t rdata,
  output logic          empty
);
  import bir_pkg::*;

  job_t       q_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign full  = cnt_r == 3'd4;
  assign empty = cnt_r == 3'd0;
  assign rdata = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      q_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) begin
        wp_r <= wp_r + 2'd1;
      end
      if (pop && !empty) begin
        rp_r <= rp_r + 2'd1;
      end
      cnt_r <= cnt_r + 3'(push && !full) - 3'(pop && !empty);
    end
  end

endmodule

@@ hw/rtl/bir_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bir_back
// Pipelined restoring dividers, in-order image bank writes, four-bank pixel
// fetch, two-step blend and output queue.
// ----------------------------------------------------------------------------
module bir_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       job_empty,
  input  bir_pkg::job_t              job,
  output logic                       job_pop,
  output logic                       out_empty,
  input  logic                       out_pop,
  output bir_pkg::out_item_t         out_data
);
  import bir_pkg::*;

  // One quotient bit per stage; 33 stages in total including entry.
  localparam int NS     = QUO_W;
  localparam int OQ     = 64;
  localparam int OQ_W   = $clog2(OQ);
  localparam int OUT_W  = $bits(out_item_t);
  localparam int PROD_W = NUM_W + DIV_W;

  typedef struct packed {
    logic             load;
    logic [7:0]       pixel;
    logic [NUM_W-1:0] rem_x;
    logic [NUM_W-1:0] rem_y;
    logic [DIV_W-1:0] dx;
    logic [DIV_W-1:0] dy;
    logic [5:0]       row;
    logic [7:0]       col;
  } dstage_t;

  logic            v_r    [NS+1];
  dstage_t         d_r    [NS+1];
  dstage_t         d_nxt  [NS+1];
  logic [NUM_W:0]  qx_r   [NS+1];
  logic [NUM_W:0]  qy_r   [NS+1];
  logic [NUM_W:0]  qx_nxt [NS+1];
  logic [NUM_W:0]  qy_nxt [NS+1];

  logic [OQ_W:0]   credit_r;
  logic            go;

  // Reserve an output queue slot for each compute item at entry.
  assign go      = !job_empty && (job.load || (credit_r != '0));
  assign job_pop = go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NS; i++) begin
        v_r[i] <= 1'b0;
      end
    end else begin
      v_r[0] <= go;
      for (int i = 1; i <= NS; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  // Stage i decides quotient bit NS-i, working on the remainder.
  always_comb begin
    logic [PROD_W-1:0] tx, ty;
    d_nxt[0].load  = job.load;
    d_nxt[0].pixel = job.pixel;
    d_nxt[0].rem_x = job.num_x;
    d_nxt[0].rem_y = job.num_y;
    d_nxt[0].dx    = job.div_x;
    d_nxt[0].dy    = job.div_y;
    d_nxt[0].row   = job.row;
    d_nxt[0].col   = job.col;
    qx_nxt[0]      = '0;
    qy_nxt[0]      = '0;
    for (int i = 1; i <= NS; i++) begin
      d_nxt[i]  = d_r[i-1];
      qx_nxt[i] = qx_r[i-1];
      qy_nxt[i] = qy_r[i-1];
      tx = PROD_W'(d_r[i-1].dx) << (NS - i);
      ty = PROD_W'(d_r[i-1].dy) << (NS - i);
      if (d_r[i-1].dx != '0 && PROD_W'(d_r[i-1].rem_x) >= tx) begin
        d_nxt[i].rem_x     = NUM_W'(PROD_W'(d_r[i-1].rem_x) - tx);
        qx_nxt[i][NS - i]  = 1'b1;
      end
      if (d_r[i-1].dy != '0 && PROD_W'(d_r[i-1].rem_y) >= ty) begin
        d_nxt[i].rem_y     = NUM_W'(PROD_W'(d_r[i-1].rem_y) - ty);
        qy_nxt[i][NS - i]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i <= NS; i++) begin
      d_r[i]  <= d_nxt[i];
      qx_r[i] <= qx_nxt[i];
      qy_r[i] <= qy_nxt[i];
    end
  end

  // Neighbour indices with saturation.
  logic [NUM_W-FRAC_BITS:0] ix, iy;
  logic [COL_W-1:0]         x0, x1;
  logic [ROW_W-1:0]         y0, y1;
  assign ix = qx_r[NS][NUM_W:FRAC_BITS];
  assign iy = qy_r[NS][NUM_W:FRAC_BITS];
  assign x0 = (ix >= (NUM_W-FRAC_BITS+1)'(SRC_WIDTH-1)) ? COL_W'(SRC_WIDTH-1) : COL_W'(ix);
  assign x1 = (ix >= (NUM_W-FRAC_BITS+1)'(SRC_WIDTH-2)) ? COL_W'(SRC_WIDTH-1)
            : COL_W'(ix + 1'b1);
  assign y0 = (iy >= (NUM_W-FRAC_BITS+1)'(MAX_SRC_ROWS-1)) ? ROW_W'(MAX_SRC_ROWS-1)
            : ROW_W'(iy);
  assign y1 = (iy >= (NUM_W-FRAC_BITS+1)'(MAX_SRC_ROWS-2)) ? ROW_W'(MAX_SRC_ROWS-1)
            : ROW_W'(iy + 1'b1);

  // Write loads at the last divider stage, so banks follow item order.
  logic              img_we;
  logic [ADDR_W-1:0] img_waddr;
  logic [7:0]        img_wdata;
  assign img_we    = v_r[NS] && d_r[NS].load;
  assign img_waddr = {d_r[NS].row, d_r[NS].col};
  assign img_wdata = d_r[NS].pixel;

  // Four copies of the image, one per neighbour.
  logic [7:0] p00, p01, p10, p11;
  bir_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_b00 (.clk, .we(img_we), .waddr(img_waddr),
    .wdata(img_wdata), .re(1'b1), .raddr({y0, x0}), .rdata(p00));
  bir_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_b01 (.clk, .we(img_we), .waddr(img_waddr),
    .wdata(img_wdata), .re(1'b1), .raddr({y0, x1}), .rdata(p01));
  bir_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_b10 (.clk, .we(img_we), .waddr(img_waddr),
    .wdata(img_wdata), .re(1'b1), .raddr({y1, x0}), .rdata(p10));
  bir_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_b11 (.clk, .we(img_we), .waddr(img_waddr),
    .wdata(img_wdata), .re(1'b1), .raddr({y1, x1}), .rdata(p11));

  logic                 f_v_r, h_v_r, a_v_r;
  logic [FRAC_BITS-1:0] f_fx_r, f_fy_r, h_fy_r;
  logic [5:0]           f_row_r, h_row_r, a_row_r;
  logic [7:0]           f_col_r, h_col_r, a_col_r;
  logic signed [8+FRAC_BITS+1:0] l1_r, l2_r;
  logic signed [ACC_W+1:0]       acc_r;
  logic signed [ACC_W+1:0]       acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
      h_v_r <= 1'b0;
      a_v_r <= 1'b0;
    end else begin
      f_v_r <= v_r[NS] && !d_r[NS].load;
      h_v_r <= f_v_r;
      a_v_r <= h_v_r;
    end
  end

  always_ff @(posedge clk) begin
    f_fx_r  <= qx_r[NS][FRAC_BITS-1:0];
    f_fy_r  <= qy_r[NS][FRAC_BITS-1:0];
    f_row_r <= d_r[NS].row;
    f_col_r <= d_r[NS].col;
    l1_r <= $signed({2'b0, p00, {FRAC_BITS{1'b0}}})
          + ($signed({2'b0, p01}) - $signed({2'b0, p00})) * $signed({1'b0, f_fx_r});
    l2_r <= $signed({2'b0, p10, {FRAC_BITS{1'b0}}})
          + ($signed({2'b0, p11}) - $signed({2'b0, p10})) * $signed({1'b0, f_fx_r});
    h_fy_r  <= f_fy_r;
    h_row_r <= f_row_r;
    h_col_r <= f_col_r;
    acc_r   <= acc_nxt;
    a_row_r <= h_row_r;
    a_col_r <= h_col_r;
  end

  assign acc_nxt = ((ACC_W+2)'(l1_r) <<< FRAC_BITS)
                 + (ACC_W+2)'(l2_r - l1_r) * (ACC_W+2)'($signed({1'b0, h_fy_r}));

  out_item_t res;
  assign res.out_pixel = acc_r[ACC_W+1] ? 8'd0 : acc_r[2*FRAC_BITS +: 8];
  assign res.pixel_row = a_row_r;
  assign res.pixel_col = a_col_r;

  // Output queue in RAM; read the next head every cycle, bypass a fresh write.
  logic [OQ_W-1:0] owp_r, orp_r, oq_raddr;
  logic [OQ_W:0]   ocnt_r;
  logic            opop;
  logic            byp_r;
  out_item_t       byp_data_r;
  out_item_t       oq_rdata;

  assign out_empty = ocnt_r == '0;
  assign opop      = out_pop && !out_empty;
  assign oq_raddr  = orp_r + OQ_W'(opop);
  assign out_data  = byp_r ? byp_data_r : oq_rdata;

  bir_ram #(.WIDTH(OUT_W), .DEPTH(OQ)) u_oq (.clk, .we(a_v_r), .waddr(owp_r),
    .wdata(res), .re(1'b1), .raddr(oq_raddr), .rdata(oq_rdata));

  always_ff @(posedge clk) begin
    byp_data_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r    <= '0;
      orp_r    <= '0;
      ocnt_r   <= '0;
      byp_r    <= 1'b0;
      credit_r <= (OQ_W+1)'(OQ);
    end else begin
      if (a_v_r) begin
        owp_r <= owp_r + 1'b1;
      end
      if (opop) begin
        orp_r <= orp_r + 1'b1;
      end
      byp_r    <= a_v_r && (owp_r == oq_raddr);
      ocnt_r   <= ocnt_r + (OQ_W+1)'(a_v_r) - (OQ_W+1)'(opop);
      credit_r <= credit_r - (OQ_W+1)'(go && !job.load) + (OQ_W+1)'(opop);
    end
  end

endmodule

@@ hw/rtl/bir_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bir_port_checker
// Port-level checks on the resampler, bound to the top level.
// ----------------------------------------------------------------------------
module bir_port_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input bir_pkg::out_item_t out_data
);

  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");
  a_full_after_reset: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty)
    else $error("waiting result dropped");
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> $stable(out_data))
    else $error("waiting result changed");

endmodule

bind bilinear_image_resampler bir_port_checker u_checker (
  .clk, .rst_n, .in_full, .out_empty, .out_pop, .out_data
);
